[rtl/tpce_pkg.sv]
// ----------------------------------------------------------------------------
// tpce_pkg: shared definitions for the typed predicate chain evaluator
// Operation, operand type and status codes, the queue geometry and the word
// that passes from the conversion front end to the evaluation back end.
// ----------------------------------------------------------------------------
package tpce_pkg;

	localparam logic [3:0] OP_NOT = 4'd0;
	localparam logic [3:0] OP_AND = 4'd1;
	localparam logic [3:0] OP_OR  = 4'd2;
	localparam logic [3:0] OP_LT  = 4'd3;
	localparam logic [3:0] OP_LTE = 4'd4;
	localparam logic [3:0] OP_GT  = 4'd5;
	localparam logic [3:0] OP_GTE = 4'd6;
	localparam logic [3:0] OP_EQ  = 4'd7;
	localparam logic [3:0] OP_NEQ = 4'd8;

	localparam logic [3:0] TYPE_BOOL = 4'd0;
	localparam logic [3:0] TYPE_I8   = 4'd1;
	localparam logic [3:0] TYPE_I16  = 4'd2;
	localparam logic [3:0] TYPE_I32  = 4'd3;
	localparam logic [3:0] TYPE_I64  = 4'd4;
	localparam logic [3:0] TYPE_U8   = 4'd5;
	localparam logic [3:0] TYPE_U16  = 4'd6;
	localparam logic [3:0] TYPE_U32  = 4'd7;
	localparam logic [3:0] TYPE_U64  = 4'd8;
	localparam logic [3:0] TYPE_F32  = 4'd9;
	localparam logic [3:0] TYPE_F64  = 4'd10;
	localparam logic [3:0] TYPE_TS   = 4'd11;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
	localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;
	localparam logic [1:0] STATUS_BAD_OP    = 2'd3;

	// Exponent of a 64-bit integer whose top bit is set, and of an f32
	// subnormal mantissa taken as an integer scaled by 2^-149.
	localparam logic [10:0] EXP_INT_BASE = 11'd1086;
	localparam logic [10:0] EXP_F32_SUB  = 11'd937;
	localparam logic [10:0] EXP_F32_BIAS = 11'd896;

	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;

	typedef struct packed {
		logic [3:0] func;
		logic       logic_ok;
		logic       cmp_ok;
		logic       first;
		logic       last;
	} tpce_meta_t;

	typedef struct packed {
		tpce_meta_t  meta;
		logic [63:0] dbl;
	} tpce_item_t;

endpackage

[rtl/tpce_front.sv]
// ----------------------------------------------------------------------------
// tpce_front: operand classification and conversion to double
// Four stages: classify and take the magnitude, count leading zeros per
// 16-bit chunk, normalise, then round to nearest even and pack.
// ----------------------------------------------------------------------------
module tpce_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [3:0]                          func,
	input  logic [3:0]                          operand_kind,
	input  logic [63:0]                         operand_bits,
	input  logic                                first_operand,
	input  logic                                last_operand,
	input  logic [tpce_pkg::QUEUE_AW:0]         queue_count,
	output logic                                item_valid,
	output tpce_pkg::tpce_item_t                item
);
	import tpce_pkg::*;

	function automatic logic [3:0] lz16(input logic [15:0] v);
		logic [3:0] n;
		logic       found;
		n = 4'd0;
		found = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					n = 4'(n + 4'd1);
			end
		end
		return n;
	endfunction

	logic        accept;
	logic [2:0]  inflight;
	logic [4:0]  occupancy;

	logic        sign_c;
	logic [63:0] mag_c;
	logic [10:0] ebase_c;
	logic        direct_c;
	logic [63:0] dir_c;
	tpce_meta_t  meta_c;

	logic        v_s1, v_s2, v_s3, v_s4;
	tpce_meta_t  meta_s1, meta_s2, meta_s3;
	logic        sign_s1, sign_s2, sign_s3;
	logic [63:0] mag_s1, mag_s2;
	logic [10:0] ebase_s1, ebase_s2;
	logic        direct_s1, direct_s2, direct_s3;
	logic [63:0] dir_s1, dir_s2, dir_s3;
	logic [15:0] chunk_lz_s2;
	logic [3:0]  chunk_nz_s2;
	logic [63:0] norm_s3;
	logic [10:0] exp_s3;
	logic        zero_s3;
	tpce_item_t  item_s4;

	logic [5:0]  lzc_c;
	logic [52:0] mant_rnd_c;
	logic        round_up_c;
	logic [10:0] exp_rnd_c;
	logic [63:0] dbl_c;

	// Every word in the pipe has a guaranteed place in the queue.
	assign inflight  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign occupancy = 5'(queue_count) + 5'(inflight);
	assign in_stall  = occupancy >= 5'(QUEUE_DEPTH);
	assign accept    = in_valid && !in_stall;

	always_comb begin
		sign_c   = 1'b0;
		mag_c    = 64'd0;
		ebase_c  = EXP_INT_BASE;
		direct_c = 1'b0;
		dir_c    = 64'd0;
		case (operand_kind)
			TYPE_BOOL, TYPE_I32: begin
				sign_c = operand_bits[31];
				mag_c  = {32'd0, sign_c ? (~operand_bits[31:0] + 32'd1) : operand_bits[31:0]};
			end
			TYPE_I8: begin
				sign_c = operand_bits[7];
				mag_c  = {56'd0, sign_c ? (~operand_bits[7:0] + 8'd1) : operand_bits[7:0]};
			end
			TYPE_I16: begin
				sign_c = operand_bits[15];
				mag_c  = {48'd0, sign_c ? (~operand_bits[15:0] + 16'd1) : operand_bits[15:0]};
			end
			TYPE_I64, TYPE_TS: begin
				sign_c = operand_bits[63];
				mag_c  = sign_c ? (~operand_bits + 64'd1) : operand_bits;
			end
			TYPE_U8:  mag_c = {56'd0, operand_bits[7:0]};
			TYPE_U16: mag_c = {48'd0, operand_bits[15:0]};
			TYPE_U32: mag_c = {32'd0, operand_bits[31:0]};
			TYPE_U64: mag_c = operand_bits;
			TYPE_F32: begin
				sign_c = operand_bits[31];
				if (operand_bits[30:23] == 8'd0 && operand_bits[22:0] != 23'd0) begin
					// A subnormal single is exact as a scaled integer.
					mag_c   = {41'd0, operand_bits[22:0]};
					ebase_c = EXP_F32_SUB;
				end else begin
					direct_c = 1'b1;
					if (operand_bits[30:23] == 8'd0)
						dir_c = {sign_c, 63'd0};
					else if (operand_bits[30:23] == 8'hFF)
						dir_c = {sign_c, 11'h7FF, operand_bits[22:0], 29'd0};
					else
						dir_c = {sign_c, 11'(operand_bits[30:23]) + EXP_F32_BIAS,
							operand_bits[22:0], 29'd0};
				end
			end
			TYPE_F64: begin
				direct_c = 1'b1;
				dir_c    = operand_bits;
			end
			default: begin
				direct_c = 1'b1;
				dir_c    = 64'd0;
			end
		endcase
		meta_c.func     = func;
		meta_c.logic_ok = operand_kind <= TYPE_F64;
		meta_c.cmp_ok   = operand_kind >= TYPE_I8 && operand_kind <= TYPE_TS;
		meta_c.first    = first_operand;
		meta_c.last     = last_operand;
	end

	always_comb begin
		if (chunk_nz_s2[3])
			lzc_c = {2'd0, chunk_lz_s2[15:12]};
		else if (chunk_nz_s2[2])
			lzc_c = {2'd1, chunk_lz_s2[11:8]};
		else if (chunk_nz_s2[1])
			lzc_c = {2'd2, chunk_lz_s2[7:4]};
		else
			lzc_c = {2'd3, chunk_lz_s2[3:0]};
	end

	always_comb begin
		round_up_c = norm_s3[10] && ((|norm_s3[9:0]) || norm_s3[11]);
		mant_rnd_c = {1'b0, norm_s3[62:11]} + 53'(round_up_c);
		exp_rnd_c  = exp_s3 + 11'(mant_rnd_c[52]);
		if (direct_s3)
			dbl_c = dir_s3;
		else if (zero_s3)
			dbl_c = 64'd0;
		else
			dbl_c = {sign_s3, exp_rnd_c, mant_rnd_c[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1   <= meta_c;
		sign_s1   <= sign_c;
		mag_s1    <= mag_c;
		ebase_s1  <= ebase_c;
		direct_s1 <= direct_c;
		dir_s1    <= dir_c;

		meta_s2   <= meta_s1;
		sign_s2   <= sign_s1;
		mag_s2    <= mag_s1;
		ebase_s2  <= ebase_s1;
		direct_s2 <= direct_s1;
		dir_s2    <= dir_s1;
		for (int k = 0; k < 4; k++) begin
			chunk_lz_s2[k*4 +: 4] <= lz16(mag_s1[k*16 +: 16]);
			chunk_nz_s2[k]        <= |mag_s1[k*16 +: 16];
		end

		meta_s3   <= meta_s2;
		sign_s3   <= sign_s2;
		direct_s3 <= direct_s2;
		dir_s3    <= dir_s2;
		norm_s3   <= mag_s2 << lzc_c;
		exp_s3    <= ebase_s2 - 11'(lzc_c);
		zero_s3   <= ~|chunk_nz_s2;

		item_s4.meta <= meta_s3;
		item_s4.dbl  <= dbl_c;
	end

	assign item_valid = v_s4;
	assign item       = item_s4;

endmodule

[rtl/tpce_fifo.sv]
// ----------------------------------------------------------------------------
// tpce_fifo: short queue between the front end and the back end
// Holds converted words; the front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module tpce_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tpce_pkg::tpce_item_t        push_item,
	input  logic                        pop,
	output logic                        not_empty,
	output tpce_pkg::tpce_item_t        head,
	output logic [tpce_pkg::QUEUE_AW:0] count
);
	import tpce_pkg::*;

	tpce_item_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign count     = count_q;

endmodule

[rtl/tpce_back.sv]
// ----------------------------------------------------------------------------
// tpce_back: list evaluation and result register
// Applies the operation to each converted word, tracks the list state and
// holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tpce_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tpce_pkg::tpce_item_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 truth
);
	import tpce_pkg::*;

	logic [3:0]  cur_op_q;
	logic [63:0] prev_q;
	logic        verd_q;
	logic        df_q;
	logic [1:0]  err_q;
	logic [1:0]  tally_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        truth_q;

	logic [3:0]  op_e;
	logic [63:0] prev_n;
	logic        verd_n;
	logic        df_n;
	logic [1:0]  err_n;
	logic [1:0]  tally_e, tally_n;
	logic [1:0]  status_n;
	logic        nz;
	logic        nan_any, zero_both, mag_lt, mag_eq;
	logic        eq, lt_ab, lt_ba, holds;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && (!head.meta.last || out_free);

	always_comb begin
		op_e    = head.meta.first ? head.meta.func : cur_op_q;
		tally_e = head.meta.first ? 2'd0 : tally_q;
		prev_n  = head.meta.first ? 64'd0 : prev_q;
		verd_n  = head.meta.first ? 1'b1 : verd_q;
		df_n    = head.meta.first ? 1'b0 : df_q;
		err_n   = head.meta.first ? STATUS_OK : err_q;

		nz = |head.dbl[62:0];

		// IEEE ordering of the previous value against the new one.
		nan_any = (&prev_n[62:52] && |prev_n[51:0]) || (&head.dbl[62:52] && |head.dbl[51:0]);
		zero_both = ~|prev_n[62:0] && ~|head.dbl[62:0];
		mag_lt  = prev_n[62:0] < head.dbl[62:0];
		mag_eq  = prev_n[62:0] == head.dbl[62:0];
		eq      = !nan_any && (zero_both || (mag_eq && prev_n[63] == head.dbl[63]));
		if (nan_any || zero_both) begin
			lt_ab = 1'b0;
			lt_ba = 1'b0;
		end else if (prev_n[63] != head.dbl[63]) begin
			lt_ab = prev_n[63];
			lt_ba = head.dbl[63];
		end else if (!prev_n[63]) begin
			lt_ab = mag_lt;
			lt_ba = !mag_lt && !mag_eq;
		end else begin
			lt_ab = !mag_lt && !mag_eq;
			lt_ba = mag_lt;
		end
		case (op_e)
			OP_LT:   holds = lt_ab;
			OP_LTE:  holds = lt_ab || eq;
			OP_GT:   holds = lt_ba;
			OP_GTE:  holds = lt_ba || eq;
			OP_EQ:   holds = eq;
			default: holds = !eq;
		endcase

		if (op_e <= OP_OR) begin
			if (tally_e == 2'd0)
				verd_n = op_e != OP_OR;
			if (!head.meta.logic_ok) begin
				if (err_n == STATUS_OK && (op_e != OP_NOT || tally_e == 2'd0))
					err_n = STATUS_BAD_TYPE;
			end else if (op_e == OP_NOT) begin
				if (tally_e == 2'd0)
					verd_n = !nz;
			end else if (op_e == OP_AND) begin
				verd_n = verd_n && nz;
			end else begin
				verd_n = verd_n || nz;
			end
		end else if (op_e <= OP_NEQ) begin
			if (err_n == STATUS_OK && !df_n) begin
				if (!head.meta.cmp_ok) begin
					err_n = STATUS_BAD_TYPE;
				end else if (tally_e == 2'd0) begin
					prev_n = head.dbl;
					verd_n = 1'b1;
				end else if (holds) begin
					prev_n = head.dbl;
				end else begin
					df_n   = 1'b1;
					verd_n = 1'b0;
				end
			end
		end

		tally_n = (tally_e == 2'd3) ? 2'd3 : tally_e + 2'd1;

		if (op_e > OP_NEQ)
			status_n = STATUS_BAD_OP;
		else if (op_e == OP_NOT && tally_n != 2'd1)
			status_n = STATUS_BAD_COUNT;
		else if (op_e >= OP_LT && tally_n < 2'd2)
			status_n = STATUS_BAD_COUNT;
		else
			status_n = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_op_q    <= OP_NOT;
			prev_q      <= 64'd0;
			verd_q      <= 1'b1;
			df_q        <= 1'b0;
			err_q       <= STATUS_OK;
			tally_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_op_q <= op_e;
				if (head.meta.last) begin
					prev_q  <= 64'd0;
					verd_q  <= 1'b1;
					df_q    <= 1'b0;
					err_q   <= STATUS_OK;
					tally_q <= 2'd0;
				end else begin
					prev_q  <= prev_n;
					verd_q  <= verd_n;
					df_q    <= df_n;
					err_q   <= err_n;
					tally_q <= tally_n;
				end
			end
			if (pop && head.meta.last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.meta.last) begin
			status_q <= status_n;
			truth_q  <= (status_n == STATUS_OK) && verd_n;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign truth     = truth_q;

endmodule

[rtl/typed_predicate_chain_evaluator_top.sv]
// ----------------------------------------------------------------------------
// typed_predicate_chain_evaluator_top: typed predicate chain evaluator
// Evaluates NOT, AND, OR and chained double comparisons over operand lists.
// ----------------------------------------------------------------------------
// One operand word can be taken every clock cycle while in_stall is low. A word
// passes through the conversion pipe and an eight-entry queue before the
// evaluator retires it, one word a cycle; out_valid comes from a register that
// is set when the last word of a list is retired. Only a list's last word
// waits for the output register. in_stall rises when the queue and the
// conversion pipe together hold eight words, which happens only after the
// output side has stalled.
module typed_predicate_chain_evaluator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [3:0]  operand_kind,
	input  logic [63:0] operand_bits,
	input  logic        first_operand,
	input  logic        last_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        truth
);
	import tpce_pkg::*;

	logic              item_valid;
	tpce_item_t        item;
	logic              head_valid;
	tpce_item_t        head;
	logic              pop;
	logic [QUEUE_AW:0] queue_count;

	tpce_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.operand_kind  (operand_kind),
		.operand_bits  (operand_bits),
		.first_operand (first_operand),
		.last_operand  (last_operand),
		.queue_count   (queue_count),
		.item_valid    (item_valid),
		.item          (item)
	);

	tpce_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid),
		.push_item (item),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head),
		.count     (queue_count)
	);

	tpce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.truth      (truth)
	);

endmodule

[rtl/tpce_checker.sv]
// ----------------------------------------------------------------------------
// tpce_checker: port-level checks for the evaluator
// Watches the output channel and the state just after reset.
// ----------------------------------------------------------------------------
module tpce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        truth
);
	import tpce_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(truth))
		else $error("result word changed while stalled");

	a_truth_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truth |-> status == STATUS_OK)
		else $error("truth set on a failed list");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not idle after reset");

endmodule

bind typed_predicate_chain_evaluator_top tpce_checker u_tpce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.truth     (truth)
);
